@@ sv/assert_macros.svh @@
// Assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// plain property, checked on every rising edge outside reset
`define RTI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: %m");
// same-cycle implication
`define RTI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");
`else
`define RTI_ASSERT(label, clk, rst_n, prop)
`define RTI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/rti_pkg.sv @@
package rti_pkg;

    // signed width of the exact dot products (|value| < 2^99)
    localparam int VW         = 104;
    // unsigned width of divider numerator / denominator
    localparam int DW         = 101;
    localparam int DIST_SHIFT = 30;
    // quotient bits: integer bit plus DIST_SHIFT fraction bits
    localparam int QW         = DIST_SHIFT + 1;

    localparam int LANE_T = 0;
    localparam int LANE_U = 1;
    localparam int LANE_V = 2;

    typedef enum logic [7:0] {
        REG_ORIGIN_X    = 8'd0,
        REG_ORIGIN_Y    = 8'd1,
        REG_ORIGIN_Z    = 8'd2,
        REG_DIR_X       = 8'd3,
        REG_DIR_Y       = 8'd4,
        REG_DIR_Z       = 8'd5,
        REG_DET_EPSILON = 8'd6,
        REG_T_MIN       = 8'd7
    } t_reg_idx;

    typedef struct packed {
        logic                  valid;
        logic                  rej;
        logic [30:0]           t_limit;
        logic [DW-1:0]         den;
        logic [2:0][DW-1:0]    num;
    } t_div_in;

    typedef struct packed {
        logic                  valid;
        logic                  rej;
        logic [30:0]           t_limit;
        logic [2:0][QW-1:0]    q;
    } t_div_out;

endpackage

@@ sv/ray_triangle_intersect.sv @@
// Ray/triangle hit test (Moller-Trumbore), fixed ray, streamed triangles.
// Pipeline: 8 arithmetic stages, 31 divider stages at one quotient bit each,
// and 1 output register between request accept and result valid.
// Throughput: one request per cycle; the whole pipe holds while the result waits.
// Reset (synchronous, active low) empties the pipe and loads the register
// defaults: origin 0, direction +z, det_epsilon 1, t_min 1.
`include "assert_macros.svh"

module ray_triangle_intersect #(
    parameter int COORD_WIDTH      = 32,
    parameter int WEIGHT_FRAC_BITS = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // triangle request
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_v0_x,
    input  logic [31:0] i_v0_y,
    input  logic [31:0] i_v0_z,
    input  logic [31:0] i_v1_x,
    input  logic [31:0] i_v1_y,
    input  logic [31:0] i_v1_z,
    input  logic [31:0] i_v2_x,
    input  logic [31:0] i_v2_y,
    input  logic [31:0] i_v2_z,
    input  logic [30:0] i_t_limit,
    // result
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_hit,
    output logic [30:0] o_hit_t,
    output logic [30:0] o_weight_v0,
    output logic [30:0] o_weight_v1,
    output logic [30:0] o_weight_v2
);

    localparam int QW  = rti_pkg::QW;
    // weights are computed with DIST_SHIFT fraction bits, then floored down
    localparam int WSH = rti_pkg::DIST_SHIFT - WEIGHT_FRAC_BITS;
    localparam logic [30:0] W_ONE = 31'(1) << WEIGHT_FRAC_BITS;

    // ---- configuration registers ----
    logic [2:0][31:0] r_org;
    logic [2:0][31:0] r_dir;
    logic [31:0]      r_eps;
    logic [30:0]      r_tmin;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org  <= '0;
            r_dir  <= {32'h4000_0000, 32'd0, 32'd0};
            r_eps  <= 32'd1;
            r_tmin <= 31'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rti_pkg::REG_ORIGIN_X:    r_org[0] <= i_cfg_data;
                rti_pkg::REG_ORIGIN_Y:    r_org[1] <= i_cfg_data;
                rti_pkg::REG_ORIGIN_Z:    r_org[2] <= i_cfg_data;
                rti_pkg::REG_DIR_X:       r_dir[0] <= i_cfg_data;
                rti_pkg::REG_DIR_Y:       r_dir[1] <= i_cfg_data;
                rti_pkg::REG_DIR_Z:       r_dir[2] <= i_cfg_data;
                rti_pkg::REG_DET_EPSILON: r_eps    <= i_cfg_data;
                rti_pkg::REG_T_MIN:       r_tmin   <= i_cfg_data[30:0];
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // ---- pipeline ----
    // Single enable: every stage moves when the output register is free or drained.
    logic r_out_valid;
    logic pipe_en;
    assign pipe_en    = !r_out_valid || i_out_ready;
    assign o_in_ready = pipe_en;

    logic [8:0][31:0]  vert;
    rti_pkg::t_div_in  front_item;
    rti_pkg::t_div_out div_item;

    assign vert = {i_v2_z, i_v2_y, i_v2_x, i_v1_z, i_v1_y, i_v1_x, i_v0_z, i_v0_y, i_v0_x};

    // edges, pvec/qvec, det and the numerators, sign fix and range checks
    rti_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (pipe_en),
        .i_valid   (i_in_valid),
        .i_vert    (vert),
        .i_t_limit (i_t_limit),
        .i_org     (r_org),
        .i_dir     (r_dir),
        .i_eps     (r_eps),
        .o_item    (front_item)
    );

    // t, u, v quotients by det
    rti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_item  (front_item),
        .o_item  (div_item)
    );

    // ---- output stage: distance window, weights, zero on miss ----
    logic [QW-1:0] tq, uq, vq;
    logic          n_hit;
    logic [30:0]   r_hit_t, r_w0, r_w1, r_w2;
    logic          r_hit;

    always_comb begin
        tq    = div_item.q[rti_pkg::LANE_T];
        uq    = div_item.q[rti_pkg::LANE_U] >> WSH;
        vq    = div_item.q[rti_pkg::LANE_V] >> WSH;
        n_hit = !div_item.rej && (tq >= r_tmin) && (tq <= div_item.t_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= div_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_hit   <= n_hit;
            r_hit_t <= n_hit ? tq : '0;
            r_w1    <= n_hit ? uq : '0;
            r_w2    <= n_hit ? vq : '0;
            r_w0    <= n_hit ? (W_ONE - uq - vq) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_hit_t     = r_hit_t;
    assign o_weight_v0 = r_w0;
    assign o_weight_v1 = r_w1;
    assign o_weight_v2 = r_w2;

    // ---- checks ----
    `RTI_ASSERT_IMP(a_weights_sum_one, i_clk, i_rst_n, o_out_valid && o_hit, (32'(o_weight_v0) + 32'(o_weight_v1) + 32'(o_weight_v2)) == 32'(W_ONE))
    `RTI_ASSERT_IMP(a_miss_is_zero, i_clk, i_rst_n, o_out_valid && !o_hit, (o_hit_t == '0) && (o_weight_v0 == '0) && (o_weight_v1 == '0) && (o_weight_v2 == '0))
    `RTI_ASSERT_IMP(a_hit_above_tmin, i_clk, i_rst_n, o_out_valid && o_hit, o_hit_t >= r_tmin)

endmodule

@@ sv/rti_front.sv @@
module rti_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [8:0][31:0]      i_vert,
    input  logic [30:0]           i_t_limit,
    input  logic [2:0][31:0]      i_org,
    input  logic [2:0][31:0]      i_dir,
    input  logic [31:0]           i_eps,
    output rti_pkg::t_div_in      o_item
);

    localparam int CWE = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int NST = 8;
    localparam int VW  = rti_pkg::VW;
    localparam int DW  = rti_pkg::DW;

    function automatic logic signed [32:0] cext(input logic [31:0] x);
        cext = {{(33 - CWE){x[CWE-1]}}, x[CWE-1:0]};
    endfunction

    logic        r_v  [NST];
    logic [30:0] r_tl [NST];

    // stage 1: edge vectors
    logic signed [32:0] r1_ab [3], r1_ac [3], r1_tv [3];
    logic signed [32:0] n1_ab [3], n1_ac [3], n1_tv [3];
    // stage 2: cross product terms
    logic signed [64:0] r2_pp [6];
    logic signed [65:0] r2_qp [6];
    logic signed [64:0] n2_pp [6];
    logic signed [65:0] n2_qp [6];
    logic signed [32:0] r2_ab [3], r2_ac [3], r2_tv [3];
    // stage 3: pvec, qvec
    logic signed [65:0] r3_pv [3];
    logic signed [66:0] r3_qv [3];
    logic signed [32:0] r3_ab [3], r3_ac [3], r3_tv [3];
    // stage 4: split partial products, index 3*group + axis
    logic signed [66:0] r4_lo [12], r4_hi [12];
    logic signed [66:0] n4_lo [12], n4_hi [12];
    // stage 5: full terms
    logic signed [VW-1:0] r5_term [12];
    // stage 6: det, un, vn, tn
    logic signed [VW-1:0] r6_sum [4];
    // stage 7: sign-normalized
    logic signed [VW-1:0] r7_sum [4];
    logic signed [VW-1:0] n7_sum [4];
    // stage 8: checks
    logic                 n8_rej;
    logic [DW-1:0]        r8_den;
    logic [2:0][DW-1:0]   r8_num;
    logic                 r8_rej;

    logic signed [32:0] dir_e [3];
    logic signed [32:0] op_a;
    logic signed [66:0] op_x;
    logic signed [33:0] x_lo, x_hi;
    logic signed [VW-1:0] eps_w;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dir_e[i] = 33'(signed'(i_dir[i]));
            n1_ab[i] = cext(i_vert[3+i]) - cext(i_vert[i]);
            n1_ac[i] = cext(i_vert[6+i]) - cext(i_vert[i]);
            n1_tv[i] = cext(i_org[i])    - cext(i_vert[i]);
        end
    end

    always_comb begin
        n2_pp[0] = 65'(dir_e[1]) * 65'(r1_ac[2]);
        n2_pp[1] = 65'(dir_e[2]) * 65'(r1_ac[1]);
        n2_pp[2] = 65'(dir_e[2]) * 65'(r1_ac[0]);
        n2_pp[3] = 65'(dir_e[0]) * 65'(r1_ac[2]);
        n2_pp[4] = 65'(dir_e[0]) * 65'(r1_ac[1]);
        n2_pp[5] = 65'(dir_e[1]) * 65'(r1_ac[0]);
        n2_qp[0] = 66'(r1_tv[1]) * 66'(r1_ab[2]);
        n2_qp[1] = 66'(r1_tv[2]) * 66'(r1_ab[1]);
        n2_qp[2] = 66'(r1_tv[2]) * 66'(r1_ab[0]);
        n2_qp[3] = 66'(r1_tv[0]) * 66'(r1_ab[2]);
        n2_qp[4] = 66'(r1_tv[0]) * 66'(r1_ab[1]);
        n2_qp[5] = 66'(r1_tv[1]) * 66'(r1_ab[0]);
    end

    // groups: det = ab.pv, un = tv.pv, vn = dir.qv, tn = ac.qv
    always_comb begin
        op_a = '0;
        op_x = '0;
        x_lo = '0;
        x_hi = '0;
        for (int g = 0; g < 4; g++) begin
            for (int i = 0; i < 3; i++) begin
                case (g)
                    0: begin
                        op_a = r3_ab[i];
                        op_x = 67'(r3_pv[i]);
                    end
                    1: begin
                        op_a = r3_tv[i];
                        op_x = 67'(r3_pv[i]);
                    end
                    2: begin
                        op_a = dir_e[i];
                        op_x = r3_qv[i];
                    end
                    default: begin
                        op_a = r3_ac[i];
                        op_x = r3_qv[i];
                    end
                endcase
                x_lo = signed'({1'b0, op_x[32:0]});
                x_hi = op_x[66:33];
                n4_lo[3*g+i] = 67'(op_a) * 67'(x_lo);
                n4_hi[3*g+i] = 67'(op_a) * 67'(x_hi);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n7_sum[k] = r6_sum[0][VW-1] ? -r6_sum[k] : r6_sum[k];
        end
    end

    // reject: det zero or small, u/v outside, t negative or >= 2 (never passes)
    always_comb begin
        eps_w  = signed'({{(VW-32){1'b0}}, i_eps});
        n8_rej = (r7_sum[0] == '0) || (r7_sum[0] < eps_w)
              || r7_sum[1][VW-1] || (r7_sum[1] > r7_sum[0])
              || r7_sum[2][VW-1] || ((r7_sum[1] + r7_sum[2]) > r7_sum[0])
              || r7_sum[3][VW-1] || (r7_sum[3] >= (r7_sum[0] <<< 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < NST; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tl[0] <= i_t_limit;
            for (int s = 1; s < NST; s++) r_tl[s] <= r_tl[s-1];
            r1_ab <= n1_ab;
            r1_ac <= n1_ac;
            r1_tv <= n1_tv;
            r2_pp <= n2_pp;
            r2_qp <= n2_qp;
            r2_ab <= r1_ab;
            r2_ac <= r1_ac;
            r2_tv <= r1_tv;
            for (int i = 0; i < 3; i++) begin
                r3_pv[i] <= 66'(r2_pp[2*i]) - 66'(r2_pp[2*i+1]);
                r3_qv[i] <= 67'(r2_qp[2*i]) - 67'(r2_qp[2*i+1]);
            end
            r3_ab <= r2_ab;
            r3_ac <= r2_ac;
            r3_tv <= r2_tv;
            r4_lo <= n4_lo;
            r4_hi <= n4_hi;
            for (int k = 0; k < 12; k++) begin
                r5_term[k] <= (VW'(r4_hi[k]) <<< 33) + VW'(r4_lo[k]);
            end
            for (int g = 0; g < 4; g++) begin
                r6_sum[g] <= r5_term[3*g] + r5_term[3*g+1] + r5_term[3*g+2];
            end
            r7_sum <= n7_sum;
            r8_rej <= n8_rej;
            r8_den <= DW'(r7_sum[0]);
            r8_num[rti_pkg::LANE_T] <= DW'(r7_sum[3]);
            r8_num[rti_pkg::LANE_U] <= DW'(r7_sum[1]);
            r8_num[rti_pkg::LANE_V] <= DW'(r7_sum[2]);
        end
    end

    assign o_item.valid   = r_v[NST-1];
    assign o_item.rej     = r8_rej;
    assign o_item.t_limit = r_tl[NST-1];
    assign o_item.den     = r8_den;
    assign o_item.num     = r8_num;

endmodule

@@ sv/rti_div.sv @@
// Restoring divider, one quotient bit per stage, three numerators share det.
module rti_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  rti_pkg::t_div_in      i_item,
    output rti_pkg::t_div_out     o_item
);

    localparam int NS = rti_pkg::QW;
    localparam int DW = rti_pkg::DW;
    localparam int QW = rti_pkg::QW;

    logic          r_v   [NS];
    logic          r_rej [NS];
    logic [30:0]   r_tl  [NS];
    logic [DW-1:0] r_den [NS];
    logic [DW-1:0] r_num [NS][3];
    logic [QW-1:0] r_q   [NS][3];
    logic [DW-1:0] n_num [NS][3];
    logic [QW-1:0] n_q   [NS][3];

    logic [DW-1:0] sh;
    logic [QW-1:0] qs;
    logic [DW-1:0] den;

    always_comb begin
        sh  = '0;
        qs  = '0;
        den = '0;
        for (int s = 0; s < NS; s++) begin
            for (int l = 0; l < 3; l++) begin
                if (s == 0) begin
                    sh  = i_item.num[l];
                    qs  = '0;
                    den = i_item.den;
                end else begin
                    sh  = r_num[s-1][l] << 1;
                    qs  = r_q[s-1][l] << 1;
                    den = r_den[s-1];
                end
                if (sh >= den) begin
                    n_num[s][l] = sh - den;
                    n_q[s][l]   = qs | QW'(1);
                end else begin
                    n_num[s][l] = sh;
                    n_q[s][l]   = qs;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_item.valid;
            for (int s = 1; s < NS; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rej[0] <= i_item.rej;
            r_tl[0]  <= i_item.t_limit;
            r_den[0] <= i_item.den;
            for (int s = 1; s < NS; s++) begin
                r_rej[s] <= r_rej[s-1];
                r_tl[s]  <= r_tl[s-1];
                r_den[s] <= r_den[s-1];
            end
            r_num <= n_num;
            r_q   <= n_q;
        end
    end

    assign o_item.valid   = r_v[NS-1];
    assign o_item.rej     = r_rej[NS-1];
    assign o_item.t_limit = r_tl[NS-1];
    assign o_item.q[rti_pkg::LANE_T] = r_q[NS-1][rti_pkg::LANE_T];
    assign o_item.q[rti_pkg::LANE_U] = r_q[NS-1][rti_pkg::LANE_U];
    assign o_item.q[rti_pkg::LANE_V] = r_q[NS-1][rti_pkg::LANE_V];

endmodule
